>>> hw/rtl/dpt_pkg.sv
// ---------------------------------------------------------------------------
// dpt_pkg
// Shared types and codes of the detection presence tracker.
// ---------------------------------------------------------------------------
package dpt_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    EV_DETECTED  = 2'd0,
    EV_CONFIRMED = 2'd1,
    EV_LOST      = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_MIN_CONFIDENCE = 2'd0,
    REG_CLASS_MASK     = 2'd1,
    REG_CONFIRM_FRAMES = 2'd2,
    REG_LOST_FRAMES    = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    TRK_NONE      = 4'b0001,
    TRK_CANDIDATE = 4'b0010,
    TRK_CONFIRMED = 4'b0100,
    TRK_LOST      = 4'b1000
  } track_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] frame;
    logic [15:0] source;
    logic [15:0] confidence;
    logic [5:0]  class_id;
    logic        last;
  } event_t;

endpackage

>>> hw/rtl/detection_presence_tracker.sv
// ---------------------------------------------------------------------------
// detection_presence_tracker
// Per-frame best detection filter feeding a presence state tracker.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per detection or frame marker. A
//   request is taken when in_valid is high and in_stall is low. Each request
//   is handled in the cycle it is taken; one item per cycle while not stalled.
//   Output channel (out_*): events (detected, confirmed, lost). A frame end
//   gives zero, one or two events; out_last_event flags the final one.
//   Events are written into a four-entry queue and handed out from it.
//   in_stall rises when fewer than two queue entries are free, so a stalled
//   receiver backs up the input after a few events; the two events of a
//   frame are handed out one at a time.
//   Configuration (cfg_*): APB-style, 64-bit data, register i at 8*i.
//   Write only while idle. pready is always high.
//   Reset (rst_n low, synchronous) empties the queue, clears the tracker and
//   frame best, and restores the register defaults.
// ---------------------------------------------------------------------------
module detection_presence_tracker #(
  parameter int NUM_CLASSES = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_has_detection,
  input  logic [15:0] in_confidence,
  input  logic [5:0]  in_class_id,
  input  logic        in_frame_end,
  input  logic [31:0] in_frame_number,
  input  logic [15:0] in_source_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_event_frame,
  output logic [15:0] out_event_source,
  output logic [15:0] out_event_confidence,
  output logic [5:0]  out_event_class,
  output logic        out_last_event
);

  localparam int CLS_IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration
  logic [15:0]            min_conf_r, confirm_r, lost_r;
  logic [NUM_CLASSES-1:0] mask_r;
  logic                   cfg_wr;
  dpt_pkg::reg_index_t    cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = dpt_pkg::reg_index_t'(cfg_paddr[4:3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r <= 16'd0;
      mask_r     <= '0;
      confirm_r  <= 16'd1;
      lost_r     <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dpt_pkg::REG_MIN_CONFIDENCE: min_conf_r <= cfg_pwdata[15:0];
        dpt_pkg::REG_CLASS_MASK:     mask_r     <= cfg_pwdata[NUM_CLASSES-1:0];
        dpt_pkg::REG_CONFIRM_FRAMES:
          confirm_r <= (cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0];
        dpt_pkg::REG_LOST_FRAMES:
          lost_r <= (cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dpt_pkg::REG_MIN_CONFIDENCE: cfg_prdata = {48'd0, min_conf_r};
      dpt_pkg::REG_CLASS_MASK:     cfg_prdata = 64'(mask_r);
      dpt_pkg::REG_CONFIRM_FRAMES: cfg_prdata = {48'd0, confirm_r};
      dpt_pkg::REG_LOST_FRAMES:    cfg_prdata = {48'd0, lost_r};
      default:                     cfg_prdata = 64'd0;
    endcase
  end

  // frame best
  logic        best_valid_r, best_valid_nxt;
  logic [15:0] best_conf_r, best_conf_nxt;
  logic [5:0]  best_cls_r, best_cls_nxt;
  logic        acc_in, cls_in_range, det_ok, take;
  logic        eff_valid;
  logic [15:0] eff_conf;
  logic [5:0]  eff_cls;

  assign acc_in       = in_valid && !in_stall;
  assign cls_in_range = (32'(in_class_id) < NUM_CLASSES);
  assign det_ok       = in_has_detection && (in_confidence >= min_conf_r) &&
                        ((mask_r == '0) ||
                         (cls_in_range && mask_r[in_class_id[CLS_IW-1:0]]));
  assign take         = det_ok && (!best_valid_r || (in_confidence > best_conf_r));
  assign eff_valid    = best_valid_r || take;
  assign eff_conf     = take ? in_confidence : best_conf_r;
  assign eff_cls      = take ? in_class_id : best_cls_r;

  // tracker
  dpt_pkg::track_state_t  st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] seen_r, seen_nxt, miss_r, miss_nxt, seen_inc, miss_inc;
  logic [15:0]            held_conf_r, held_conf_nxt;
  logic [5:0]             held_cls_r, held_cls_nxt;
  logic                   ev_det, ev_conf, ev_lost;

  assign seen_inc = (seen_r == COUNT_MAX) ? seen_r : seen_r + 1'b1;
  assign miss_inc = (miss_r == COUNT_MAX) ? miss_r : miss_r + 1'b1;

  always_comb begin
    st_nxt         = st_r;
    seen_nxt       = seen_r;
    miss_nxt       = miss_r;
    held_conf_nxt  = held_conf_r;
    held_cls_nxt   = held_cls_r;
    best_valid_nxt = best_valid_r;
    best_conf_nxt  = best_conf_r;
    best_cls_nxt   = best_cls_r;
    ev_det         = 1'b0;
    ev_conf        = 1'b0;
    ev_lost        = 1'b0;
    if (acc_in) begin
      best_valid_nxt = eff_valid;
      best_conf_nxt  = eff_conf;
      best_cls_nxt   = eff_cls;
      if (in_frame_end) begin
        best_valid_nxt = 1'b0;
        best_conf_nxt  = 16'd0;
        best_cls_nxt   = 6'd0;
        if (eff_valid) begin
          held_conf_nxt = eff_conf;
          held_cls_nxt  = eff_cls;
          miss_nxt      = '0;
          seen_nxt      = seen_inc;
          if (st_r == dpt_pkg::TRK_NONE || st_r == dpt_pkg::TRK_LOST) begin
            seen_nxt = COUNT_WIDTH'(1);
            ev_det   = 1'b1;
            if (32'(confirm_r) <= 32'd1) begin
              st_nxt  = dpt_pkg::TRK_CONFIRMED;
              ev_conf = 1'b1;
            end else begin
              st_nxt = dpt_pkg::TRK_CANDIDATE;
            end
          end else if (st_r == dpt_pkg::TRK_CANDIDATE &&
                       32'(seen_inc) >= 32'(confirm_r)) begin
            st_nxt  = dpt_pkg::TRK_CONFIRMED;
            ev_conf = 1'b1;
          end
        end else begin
          seen_nxt = '0;
          case (st_r)
            dpt_pkg::TRK_CANDIDATE: begin
              st_nxt        = dpt_pkg::TRK_NONE;
              held_conf_nxt = 16'd0;
              held_cls_nxt  = 6'd0;
            end
            dpt_pkg::TRK_CONFIRMED: begin
              miss_nxt = miss_inc;
              if (32'(miss_inc) >= 32'(lost_r)) begin
                st_nxt  = dpt_pkg::TRK_LOST;
                ev_lost = 1'b1;
              end
            end
            dpt_pkg::TRK_LOST: begin
              st_nxt        = dpt_pkg::TRK_NONE;
              miss_nxt      = '0;
              held_conf_nxt = 16'd0;
              held_cls_nxt  = 6'd0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= dpt_pkg::TRK_NONE;
      seen_r       <= '0;
      miss_r       <= '0;
      held_conf_r  <= 16'd0;
      held_cls_r   <= 6'd0;
      best_valid_r <= 1'b0;
      best_conf_r  <= 16'd0;
      best_cls_r   <= 6'd0;
    end else begin
      st_r         <= st_nxt;
      seen_r       <= seen_nxt;
      miss_r       <= miss_nxt;
      held_conf_r  <= held_conf_nxt;
      held_cls_r   <= held_cls_nxt;
      best_valid_r <= best_valid_nxt;
      best_conf_r  <= best_conf_nxt;
      best_cls_r   <= best_cls_nxt;
    end
  end

  // event assembly
  dpt_pkg::event_t ev0, ev1, head;
  logic [1:0]      ev_cnt;
  logic [dpt_pkg::FIFO_CNT_W-1:0] q_cnt;

  always_comb begin
    ev_cnt          = 2'(ev_det) + 2'(ev_conf) + 2'(ev_lost);
    ev0.kind        = ev_det ? dpt_pkg::EV_DETECTED :
                      (ev_conf ? dpt_pkg::EV_CONFIRMED : dpt_pkg::EV_LOST);
    ev0.frame       = in_frame_number;
    ev0.source      = in_source_number;
    ev0.confidence  = held_conf_nxt;
    ev0.class_id    = held_cls_nxt;
    ev0.last        = (ev_cnt == 2'd1);
    ev1             = ev0;
    ev1.kind        = dpt_pkg::EV_CONFIRMED;
    ev1.last        = 1'b1;
  end

  dpt_event_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (ev_cnt),
    .wr_ev0    (ev0),
    .wr_ev1    (ev1),
    .rd        (!out_stall),
    .head      (head),
    .not_empty (out_valid),
    .count     (q_cnt)
  );

  assign in_stall             = (32'(q_cnt) > dpt_pkg::FIFO_DEPTH - 2);
  assign out_event_kind       = head.kind;
  assign out_event_frame      = head.frame;
  assign out_event_source     = head.source;
  assign out_event_confidence = head.confidence;
  assign out_event_class      = head.class_id;
  assign out_last_event       = head.last;

endmodule

>>> hw/rtl/dpt_event_fifo.sv
// ---------------------------------------------------------------------------
// dpt_event_fifo
// Small event queue: takes zero, one or two events per cycle, hands out one.
// ---------------------------------------------------------------------------
module dpt_event_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       wr_cnt,
  input  dpt_pkg::event_t                  wr_ev0,
  input  dpt_pkg::event_t                  wr_ev1,
  input  logic                             rd,
  output dpt_pkg::event_t                  head,
  output logic                             not_empty,
  output logic [dpt_pkg::FIFO_CNT_W-1:0]   count
);

  dpt_pkg::event_t                   mem_r [dpt_pkg::FIFO_DEPTH];
  logic [dpt_pkg::FIFO_PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [dpt_pkg::FIFO_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                              do_rd;

  assign do_rd     = rd && (cnt_r != '0);
  assign wp1       = wp_r + 1'b1;
  assign head      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  always_comb begin
    wp_nxt  = wp_r + dpt_pkg::FIFO_PTR_W'(wr_cnt);
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + dpt_pkg::FIFO_CNT_W'(wr_cnt) - dpt_pkg::FIFO_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wp_r] <= wr_ev0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wp1] <= wr_ev1;
    end
  end

endmodule

>>> hw/rtl/dpt_checker.sv
// ---------------------------------------------------------------------------
// dpt_checker
// Port-level checks of the detection presence tracker, bound to the top.
// ---------------------------------------------------------------------------
module dpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic [31:0] out_event_frame,
  input logic        out_last_event
);

  // held event must not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) &&
    $stable(out_event_frame) && $stable(out_last_event))
    else $error("event changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event pending after reset");

  // an empty queue always has room
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty queue");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == dpt_pkg::EV_DETECTED ||
                   out_event_kind == dpt_pkg::EV_CONFIRMED ||
                   out_event_kind == dpt_pkg::EV_LOST))
    else $error("bad event kind");

  // only a detected event can be followed by another from the same frame
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_event |-> out_event_kind == dpt_pkg::EV_DETECTED)
    else $error("non-final event is not detected");

endmodule

bind detection_presence_tracker dpt_checker u_dpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_kind (out_event_kind),
  .out_event_frame(out_event_frame),
  .out_last_event (out_last_event)
);
